// ===== rtl/waveform_generator_rc_filter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the waveform generator with RC low-pass
// Expect clk_i and rst_ni in scope wherever these are used.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_GENERATOR_RC_FILTER_UNIT_ASSERT_SVH
`define WAVEFORM_GENERATOR_RC_FILTER_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define WGRC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define WGRC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wgrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgrc_pkg
// Shared types, constants and helper functions of the waveform generator.
// ----------------------------------------------------------------------------
package wgrc_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  // Fixed widths
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_W      = 32;   // phase fraction seen by the shaper
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned ROM_W       = 16;
  localparam int unsigned MUL_A_W     = 33;
  localparam int unsigned MUL_B_W     = 25;
  localparam int unsigned MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned RAW_W       = 28;   // unsaturated source and cap sums
  localparam int unsigned OPB_W       = 24;

  // Half and full period on a 33-bit scale
  localparam logic [FRAC_W:0] HALF_T = 33'h0_8000_0000;
  localparam logic [FRAC_W:0] FULL_T = 33'h1_0000_0000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [2:0] {
    WAVE_CONST = 3'd0,
    WAVE_SINE  = 3'd1,
    WAVE_TRI   = 3'd2,
    WAVE_SAW   = 3'd3,
    WAVE_HALF  = 3'd4,
    WAVE_RECT  = 3'd5,
    WAVE_TRAP  = 3'd6
  } wave_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVEFORM   = 3'd0,
    CFG_AMPLITUDE  = 3'd1,
    CFG_PHASE_INC  = 3'd2,
    CFG_EDGE_PHASE = 3'd3,
    CFG_RAMP_GAIN  = 3'd4,
    CFG_EDGE_SLOPE = 3'd5,
    CFG_RC_COEFF   = 3'd6
  } cfg_idx_e;

  // How the source product is shaped into a sample
  typedef enum logic [3:0] {
    POST_ZERO,
    POST_POS_A,
    POST_NEG_A,
    POST_SINE_POS,
    POST_SINE_NEG,
    POST_TRI_RISE,
    POST_TRI_FALL,
    POST_SAW_RISE,
    POST_EDGE_FALL,
    POST_EDGE_RISE,
    POST_EDGE_NEG
  } post_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SRC,
    ST_FMUL,
    ST_CAP
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic src_en;
    logic cap_en;
  } ctrl_t;

  // Register reset values
  localparam logic [2:0]  WAVEFORM_RST   = WAVE_SINE;
  localparam logic [14:0] AMPLITUDE_RST  = 15'd16384;
  localparam logic [31:0] PHASE_INC_RST  = 32'd42949673;
  localparam logic [30:0] EDGE_PHASE_RST = 31'd0;
  localparam logic [17:0] RAMP_GAIN_RST  = 18'd65536;
  localparam logic [23:0] EDGE_SLOPE_RST = 24'd1000000;
  localparam logic [15:0] RC_COEFF_RST   = 16'd655;

  localparam logic signed [RAW_W-1:0] SAT_MAX = RAW_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [RAW_W-1:0] SAT_MIN = -SAT_MAX - RAW_W'(1);

  // Series coefficients of sin(pi/2 * x), Horner order, Q30
  localparam logic [63:0] SINE_COEF [5] = '{
    64'd172273, 64'd5026994, 64'd85569306, 64'd693598668, 64'd1686629713
  };

  // Clamp to the signed sample range
  function automatic sample_t sat_sample(logic signed [RAW_W-1:0] v);
    sample_t r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  // One quarter-wave table entry in Q15, evaluated at elaboration
  function automatic logic [ROM_W-1:0] sine_entry(int unsigned k, int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] y;
    logic [63:0] q;
    x  = 64'(k) << (30 - tbits);
    x2 = (x * x) >> 30;
    s  = SINE_COEF[0];
    for (int i = 1; i < 5; i++) begin
      s = SINE_COEF[i] - ((x2 * s) >> 30);
    end
    y = (x * s) >> 30;
    q = (y + 64'd16384) >> 15;
    if (q > 64'd32768) begin
      q = 64'd32768;
    end
    return q[ROM_W-1:0];
  endfunction

endpackage

// ===== rtl/wgrc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgrc channel interfaces
// Step input, result output and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface wgrc_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface wgrc_out_if;
  logic              valid;
  logic              ready;
  wgrc_pkg::sample_t source_value;
  wgrc_pkg::sample_t cap_value;
  modport source (output valid, output source_value, output cap_value, input ready);
  modport sink   (input valid, input source_value, input cap_value, output ready);
endinterface

interface wgrc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wgrc_pkg::CFG_IDX_W-1:0]    index;
  logic [wgrc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/wgrc_sine_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgrc_sine_rom
// Quarter-wave sine table, Q15, one registered read per cycle while enabled.
// ----------------------------------------------------------------------------
module wgrc_sine_rom #(
  parameter int unsigned TABLE_BITS = wgrc_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [TABLE_BITS:0]          addr_i,
  output logic [wgrc_pkg::ROM_W-1:0]   data_o
);

  localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

  typedef logic [wgrc_pkg::ROM_W-1:0] rom_t [DEPTH];

  // Fill the table from the series at elaboration
  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < DEPTH; k++) begin
      t[k] = wgrc_pkg::sine_entry(k, TABLE_BITS);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [wgrc_pkg::ROM_W-1:0] data_q;

  // Registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ROM[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/wgrc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgrc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wgrc_mul (
  input  logic                                 clk_i,
  input  logic signed [wgrc_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [wgrc_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [wgrc_pkg::MUL_P_W-1:0]  p_o
);

  logic signed [wgrc_pkg::MUL_P_W-1:0] p_q;

  // Register the full product
  always_ff @(posedge clk_i) begin
    p_q <= wgrc_pkg::MUL_P_W'(a_i) * wgrc_pkg::MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/wgrc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgrc_ctrl
// Step sequencer: source multiply, shaping, filter multiply, capacitor update.
// ----------------------------------------------------------------------------
module wgrc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_busy_i,
  output wgrc_pkg::ctrl_t ctrl_o
);

  wgrc_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wgrc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wgrc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = wgrc_pkg::ST_MUL;
      end
      wgrc_pkg::ST_MUL:  state_d = wgrc_pkg::ST_SRC;
      wgrc_pkg::ST_SRC:  state_d = wgrc_pkg::ST_FMUL;
      wgrc_pkg::ST_FMUL: state_d = wgrc_pkg::ST_CAP;
      wgrc_pkg::ST_CAP: begin
        // hold until the output register has room
        if (!out_busy_i) state_d = wgrc_pkg::ST_IDLE;
      end
      default: state_d = wgrc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.in_ready = (state_q == wgrc_pkg::ST_IDLE);
    ctrl_o.load     = (state_q == wgrc_pkg::ST_IDLE) && in_valid_i;
    ctrl_o.src_en   = (state_q == wgrc_pkg::ST_SRC);
    ctrl_o.cap_en   = (state_q == wgrc_pkg::ST_CAP) && !out_busy_i;
  end

endmodule

// ===== rtl/waveform_generator_rc_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_generator_rc_filter_unit
// Phase-accumulator waveform source driving a forward-Euler RC low-pass.
// ----------------------------------------------------------------------------
// Each input word is one time step and yields one output word carrying the
// source sample and the capacitor level after the step. A step runs, the
// accepting cycle included, through operand set-up with the sine table read,
// the source multiply, shaping and saturation, the filter multiply, and the
// capacitor update. Its result passes the operand registers, the product,
// the filter operand registers and the product again before the output
// register takes it. The next word is taken as soon as the step has finished,
// while its result may still wait in the output register; the update stage
// holds only if that register is still occupied. Steps are serialised by
// the single 33x25 multiplier, used once for the source and once for the
// filter in every step. The sine table is a constant ROM, so no clearing
// pass follows reset. Restart clears phase and capacitor first.
// ----------------------------------------------------------------------------
module waveform_generator_rc_filter_unit #(
  parameter int unsigned PHASE_BITS      = wgrc_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = wgrc_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wgrc_cfg_if.sink   cfg_i,
  wgrc_in_if.sink    in_i,
  wgrc_out_if.source out_o
);

  `include "waveform_generator_rc_filter_unit_assert.svh"

  localparam int unsigned FW     = wgrc_pkg::FRAC_W;
  localparam int unsigned AW     = wgrc_pkg::MUL_A_W;
  localparam int unsigned BW     = wgrc_pkg::MUL_B_W;
  localparam int unsigned PW     = wgrc_pkg::MUL_P_W;
  localparam int unsigned RW     = wgrc_pkg::RAW_W;
  localparam int unsigned OBW    = wgrc_pkg::OPB_W;
  localparam int unsigned SB     = wgrc_pkg::SAMPLE_BITS;
  localparam int unsigned DW     = SB + 1;
  localparam int unsigned ADDR_W = SINE_TABLE_BITS + 1;

  // Configuration registers
  logic [2:0]  waveform_q;
  logic [14:0] amplitude_q;
  logic [31:0] phase_inc_q;
  logic [30:0] edge_phase_q;
  logic [17:0] ramp_gain_q;
  logic [23:0] edge_slope_q;
  logic [15:0] rc_coeff_q;

  // Step state and datapath
  logic [PHASE_BITS-1:0]    phase_q, phase_eff, phase_inc;
  wgrc_pkg::sample_t        cap_q, src_q;
  logic [FW-1:0]            f_next;
  logic [FW:0]              f33, e33, t_minus_e, h_minus_e, h_plus_e;
  logic signed [AW-1:0]     op_a_q, op_a_d;
  logic [OBW-1:0]           op_b_q, op_b_d;
  logic                     use_rom_q, use_rom_d;
  wgrc_pkg::post_e          post_q, post_d;
  logic [ADDR_W-1:0]        rom_addr, rom_idx, quarter;
  logic [wgrc_pkg::ROM_W-1:0] rom_data;
  logic signed [AW-1:0]     mul_a;
  logic signed [BW-1:0]     mul_b;
  logic signed [PW-1:0]     prod;
  logic signed [RW-1:0]     amp_r, r30, r32, msin, src_raw, cap_sum;
  logic signed [RW-1:0]     cap_step;
  wgrc_pkg::sample_t        src_sat, cap_new;
  logic signed [DW-1:0]     diff;
  wgrc_pkg::ctrl_t          ctrl;
  logic                     out_valid_q;
  wgrc_pkg::sample_t        out_src_q, out_cap_q;
  logic                     out_busy;

  // Register writes; the port never stalls
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q   <= wgrc_pkg::WAVEFORM_RST;
      amplitude_q  <= wgrc_pkg::AMPLITUDE_RST;
      phase_inc_q  <= wgrc_pkg::PHASE_INC_RST;
      edge_phase_q <= wgrc_pkg::EDGE_PHASE_RST;
      ramp_gain_q  <= wgrc_pkg::RAMP_GAIN_RST;
      edge_slope_q <= wgrc_pkg::EDGE_SLOPE_RST;
      rc_coeff_q   <= wgrc_pkg::RC_COEFF_RST;
    end else if (cfg_i.valid) begin
      case (wgrc_pkg::cfg_idx_e'(cfg_i.index))
        wgrc_pkg::CFG_WAVEFORM:   waveform_q   <= cfg_i.data[2:0];
        wgrc_pkg::CFG_AMPLITUDE:  amplitude_q  <= cfg_i.data[14:0];
        wgrc_pkg::CFG_PHASE_INC:  phase_inc_q  <= cfg_i.data[31:0];
        wgrc_pkg::CFG_EDGE_PHASE: edge_phase_q <= cfg_i.data[30:0];
        wgrc_pkg::CFG_RAMP_GAIN:  ramp_gain_q  <= cfg_i.data[17:0];
        wgrc_pkg::CFG_EDGE_SLOPE: edge_slope_q <= cfg_i.data[23:0];
        wgrc_pkg::CFG_RC_COEFF:   rc_coeff_q   <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  assign out_busy = out_valid_q && !out_o.ready;

  wgrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  assign in_i.ready = ctrl.in_ready;

  // Phase after an optional restart, and its top fraction bits
  assign phase_eff = in_i.restart ? '0 : phase_q;

  if (PHASE_BITS >= FW) begin : g_wide
    localparam int unsigned UP = PHASE_BITS - FW;
    assign f_next    = phase_eff[PHASE_BITS-1 -: FW];
    assign phase_inc = PHASE_BITS'(phase_inc_q) << UP;
  end else begin : g_narrow
    localparam int unsigned DN = FW - PHASE_BITS;
    assign f_next    = FW'(phase_eff) << DN;
    assign phase_inc = phase_inc_q[FW-1 -: PHASE_BITS];
  end

  // Sine table address: mirror odd quadrants
  assign quarter  = ADDR_W'(1) << SINE_TABLE_BITS;
  assign rom_idx  = {1'b0, f_next[FW-3 -: SINE_TABLE_BITS]};
  assign rom_addr = f_next[FW-2] ? (quarter - rom_idx) : rom_idx;

  wgrc_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (ctrl.load),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // Segment boundaries on a 33-bit scale
  assign f33       = {1'b0, f_next};
  assign e33       = (FW + 1)'(edge_phase_q);
  assign t_minus_e = wgrc_pkg::FULL_T - e33;
  assign h_minus_e = wgrc_pkg::HALF_T - e33;
  assign h_plus_e  = wgrc_pkg::HALF_T + e33;

  // Pick multiplier operands and shaping for the source
  always_comb begin
    op_a_d    = AW'(f33);
    op_b_d    = edge_slope_q;
    use_rom_d = 1'b0;
    post_d    = wgrc_pkg::POST_ZERO;
    case (wgrc_pkg::wave_e'(waveform_q))
      wgrc_pkg::WAVE_CONST: post_d = wgrc_pkg::POST_POS_A;
      wgrc_pkg::WAVE_SINE: begin
        op_a_d    = AW'(amplitude_q);
        use_rom_d = 1'b1;
        post_d    = f_next[FW-1] ? wgrc_pkg::POST_SINE_NEG : wgrc_pkg::POST_SINE_POS;
      end
      wgrc_pkg::WAVE_HALF: begin
        op_a_d    = AW'(amplitude_q);
        use_rom_d = 1'b1;
        post_d    = f_next[FW-1] ? wgrc_pkg::POST_ZERO : wgrc_pkg::POST_SINE_POS;
      end
      wgrc_pkg::WAVE_RECT: begin
        op_a_d    = AW'(amplitude_q);
        use_rom_d = 1'b1;
        post_d    = wgrc_pkg::POST_SINE_POS;
      end
      wgrc_pkg::WAVE_TRI: begin
        op_b_d = OBW'(amplitude_q);
        post_d = (f33 <= wgrc_pkg::HALF_T) ? wgrc_pkg::POST_TRI_RISE
                                           : wgrc_pkg::POST_TRI_FALL;
      end
      wgrc_pkg::WAVE_SAW: begin
        if (f33 <= t_minus_e) begin
          op_b_d = OBW'(ramp_gain_q);
          post_d = wgrc_pkg::POST_SAW_RISE;
        end else begin
          op_a_d = AW'(f33 - t_minus_e);
          post_d = wgrc_pkg::POST_EDGE_FALL;
        end
      end
      wgrc_pkg::WAVE_TRAP: begin
        // first matching segment wins
        if (f33 <= e33) begin
          post_d = wgrc_pkg::POST_EDGE_RISE;
        end else if (f33 <= h_minus_e) begin
          post_d = wgrc_pkg::POST_POS_A;
        end else if (f33 <= h_plus_e) begin
          op_a_d = AW'(f33 - h_minus_e);
          post_d = wgrc_pkg::POST_EDGE_FALL;
        end else if (f33 <= t_minus_e) begin
          post_d = wgrc_pkg::POST_NEG_A;
        end else begin
          op_a_d = AW'(f33 - t_minus_e);
          post_d = wgrc_pkg::POST_EDGE_NEG;
        end
      end
      default: post_d = wgrc_pkg::POST_ZERO;
    endcase
  end

  // Shared multiplier
  assign mul_a = op_a_q;
  assign mul_b = use_rom_q ? BW'(rom_data) : BW'(op_b_q);

  wgrc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Shape the source product and saturate
  assign amp_r = RW'(amplitude_q);
  assign r30   = RW'(prod >>> 30);
  assign r32   = RW'(prod >>> 32);
  assign msin  = RW'((prod + PW'(16384)) >>> 15);

  always_comb begin
    case (post_q)
      wgrc_pkg::POST_ZERO:      src_raw = '0;
      wgrc_pkg::POST_POS_A:     src_raw = amp_r;
      wgrc_pkg::POST_NEG_A:     src_raw = -amp_r;
      wgrc_pkg::POST_SINE_POS:  src_raw = msin;
      wgrc_pkg::POST_SINE_NEG:  src_raw = -msin;
      wgrc_pkg::POST_TRI_RISE:  src_raw = r30 - amp_r;
      wgrc_pkg::POST_TRI_FALL:  src_raw = (amp_r <<< 1) + amp_r - r30;
      wgrc_pkg::POST_SAW_RISE:  src_raw = r32 - amp_r;
      wgrc_pkg::POST_EDGE_FALL: src_raw = amp_r - r32;
      wgrc_pkg::POST_EDGE_RISE: src_raw = r32;
      wgrc_pkg::POST_EDGE_NEG:  src_raw = r32 - amp_r;
      default:                  src_raw = '0;
    endcase
  end

  assign src_sat = wgrc_pkg::sat_sample(src_raw);
  assign diff    = DW'(src_sat) - DW'(cap_q);

  // Euler step: round the filter product, add and saturate
  assign cap_step = RW'((prod + PW'(32768)) >>> 16);
  assign cap_sum  = RW'(cap_q) + cap_step;
  assign cap_new  = wgrc_pkg::sat_sample(cap_sum);

  // Operand registers: source operands at acceptance, filter operands after shaping
  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      op_a_q    <= op_a_d;
      op_b_q    <= op_b_d;
      use_rom_q <= use_rom_d;
      post_q    <= post_d;
    end else if (ctrl.src_en) begin
      op_a_q    <= AW'(diff);
      op_b_q    <= OBW'(rc_coeff_q);
      use_rom_q <= 1'b0;
      src_q     <= src_sat;
    end
  end

  // Phase and capacitor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      cap_q   <= '0;
    end else if (ctrl.load) begin
      phase_q <= phase_eff + phase_inc;
      if (in_i.restart) cap_q <= '0;
    end else if (ctrl.cap_en) begin
      cap_q <= cap_new;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.cap_en) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.cap_en) begin
      out_src_q <= src_q;
      out_cap_q <= cap_new;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.source_value = out_src_q;
  assign out_o.cap_value    = out_cap_q;

  // Checks on sequencing and datapath hand-over
  `WGRC_ASSERT_NEXT(a_busy_after_load, ctrl.load, !ctrl.in_ready, "ready after a word was taken")
  `WGRC_ASSERT_NEXT(a_out_after_update, ctrl.cap_en, out_valid_q, "result not registered")
  `WGRC_ASSERT_NEXT(a_filter_not_rom, ctrl.src_en, !use_rom_q, "filter multiply fed from ROM")
  `WGRC_ASSERT_NEXT(a_restart_clears, ctrl.load && in_i.restart, cap_q == '0, "restart kept cap")

endmodule
